[rtl/obbcp_pkg.sv]
// shared types, widths and helpers for the oriented box closest point block
`timescale 1ns / 1ps
`default_nettype none

package obbcp_pkg;

    // geometry
    localparam int AXES        = 3;
    localparam int WORD_W      = 16;
    localparam int AXIS_FRAC   = 14;

    // port widths
    localparam int CFG_W       = 48;
    localparam int REG_ADDR_W  = 3;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 56;

    // datapath widths
    localparam int D_W         = WORD_W + 1;
    localparam int PROD_W      = D_W + WORD_W;
    localparam int PROJ_W      = PROD_W + 2;
    localparam int CPROD_W     = PROJ_W + WORD_W;
    localparam int ACC_W       = CPROD_W + 2;
    localparam int FRAC_SHIFT  = 28;
    localparam int OFF_W       = ACC_W - FRAC_SHIFT;
    localparam int SUM_W       = OFF_W + 1;

    // rounding and saturation constants
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_SHIFT - 1);
    localparam logic signed [SUM_W-1:0] SAT_HI     = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_LO     = -SUM_W'(32768);

    // register reset values
    localparam logic [CFG_W-1:0] RST_CENTER = '0;
    localparam logic [CFG_W-1:0] RST_AXIS_U = 48'h0000_0000_4000;
    localparam logic [CFG_W-1:0] RST_AXIS_V = 48'h0000_4000_0000;
    localparam logic [CFG_W-1:0] RST_AXIS_W = 48'h4000_0000_0000;
    localparam logic [CFG_W-1:0] RST_EXT    = '0;

    // register indexes
    typedef enum logic [REG_ADDR_W-1:0] {
        REG_CENTER = 3'd0,
        REG_AXIS_U = 3'd1,
        REG_AXIS_V = 3'd2,
        REG_AXIS_W = 3'd3,
        REG_EXT    = 3'd4
    } t_reg_idx;

    // box description held by the register file
    typedef struct packed {
        logic [CFG_W-1:0] center;
        logic [CFG_W-1:0] axis_u;
        logic [CFG_W-1:0] axis_v;
        logic [CFG_W-1:0] axis_w;
        logic [CFG_W-1:0] ext;
    } t_box_cfg;

    // handoff from projection to rebuild
    typedef struct packed {
        logic                          valid;
        logic                          in_box;
        logic [AXES-1:0][PROJ_W-1:0]   proj;
    } t_proj_bus;

    // one signed 16-bit word of a packed register
    function automatic logic signed [WORD_W-1:0] word_s(
        input logic [CFG_W-1:0] r,
        input logic [1:0]       k
    );
        return $signed(r[WORD_W*k +: WORD_W]);
    endfunction

    // one unsigned 16-bit word of a packed register
    function automatic logic [WORD_W-1:0] word_u(
        input logic [CFG_W-1:0] r,
        input logic [1:0]       k
    );
        return r[WORD_W*k +: WORD_W];
    endfunction

    // axis register by axis number
    function automatic logic [CFG_W-1:0] axis_of(
        input t_box_cfg   cfg,
        input logic [1:0] i
    );
        logic [CFG_W-1:0] a;
        unique case (i)
            2'd0: a = cfg.axis_u;
            2'd1: a = cfg.axis_v;
            default: a = cfg.axis_w;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

[rtl/obb_closest_point.sv]
// top level: register file and the two pipeline halves
`timescale 1ns / 1ps
`default_nettype none

// Closest point on an oriented box. Each transfer on the input stream carries one
// signed Q8.8 point; the matching output transfer carries the nearest point on or
// in the box (saturated Q8.8) and an inside flag. While the output is not stalled, the
// block accepts one point per cycle and returns results in order through six
// register stages: offset, axis products, dot sum and clamp, rebuild products,
// axis sum, round and saturate. Output backpressure stalls the whole pipeline
// without loss; bubbles are squeezed out. The box registers are written through
// the plain write port and must only change while the pipeline is empty.

module obb_closest_point (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output      logic                              o_s_tready,
    // point_x, point_y, point_z
    input  wire logic [obbcp_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output      logic                              o_m_tvalid,
    input  wire logic                              i_m_tready,
    // near_x, near_y, near_z, inside_res, zero fill
    output      logic [obbcp_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input  wire logic                              i_cfg_we,
    input  wire logic [obbcp_pkg::REG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [obbcp_pkg::CFG_W-1:0]       i_cfg_data
);

    obbcp_pkg::t_box_cfg  r_cfg;
    obbcp_pkg::t_proj_bus proj_bus;
    logic                 rb_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center <= obbcp_pkg::RST_CENTER;
            r_cfg.axis_u <= obbcp_pkg::RST_AXIS_U;
            r_cfg.axis_v <= obbcp_pkg::RST_AXIS_V;
            r_cfg.axis_w <= obbcp_pkg::RST_AXIS_W;
            r_cfg.ext    <= obbcp_pkg::RST_EXT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                obbcp_pkg::REG_CENTER: r_cfg.center <= i_cfg_data;
                obbcp_pkg::REG_AXIS_U: r_cfg.axis_u <= i_cfg_data;
                obbcp_pkg::REG_AXIS_V: r_cfg.axis_v <= i_cfg_data;
                obbcp_pkg::REG_AXIS_W: r_cfg.axis_w <= i_cfg_data;
                obbcp_pkg::REG_EXT:    r_cfg.ext    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // projection and clamp
    obbcp_proj u_proj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_data  (i_s_tdata),
        .o_bus   (proj_bus),
        .i_ready (rb_ready)
    );

    // rebuild and output register
    obbcp_rebuild u_rebuild (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_bus   (proj_bus),
        .o_ready (rb_ready),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (o_m_tdata)
    );

endmodule

`default_nettype wire

[rtl/obbcp_proj.sv]
// offset, axis projection and clamp stages
`timescale 1ns / 1ps
`default_nettype none

module obbcp_proj (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire obbcp_pkg::t_box_cfg               i_cfg,
    input  wire logic                              i_valid,
    output      logic                              o_ready,
    input  wire logic [obbcp_pkg::IN_TDATA_W-1:0]  i_data,
    output      obbcp_pkg::t_proj_bus              o_bus,
    input  wire logic                              i_ready
);

    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;

    logic signed [obbcp_pkg::D_W-1:0]    r_d    [obbcp_pkg::AXES];
    logic signed [obbcp_pkg::D_W-1:0]    n_d    [obbcp_pkg::AXES];
    logic signed [obbcp_pkg::PROD_W-1:0] r_prod [obbcp_pkg::AXES][obbcp_pkg::AXES];
    logic signed [obbcp_pkg::PROD_W-1:0] n_prod [obbcp_pkg::AXES][obbcp_pkg::AXES];
    logic signed [obbcp_pkg::PROJ_W-1:0] r_proj [obbcp_pkg::AXES];
    logic signed [obbcp_pkg::PROJ_W-1:0] n_proj [obbcp_pkg::AXES];
    logic                                r_inside;
    logic                                n_inside;

    // stage enables ripple back from the consumer
    assign en3     = !r_v3 || i_ready;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;

    // stage 1: offset from box center
    always_comb begin
        for (int k = 0; k < obbcp_pkg::AXES; k++) begin
            n_d[k] = $signed(i_data[obbcp_pkg::WORD_W*k +: obbcp_pkg::WORD_W])
                   - obbcp_pkg::word_s(i_cfg.center, 2'(k));
        end
    end

    // stage 2: component products against each axis
    always_comb begin
        for (int i = 0; i < obbcp_pkg::AXES; i++) begin
            for (int k = 0; k < obbcp_pkg::AXES; k++) begin
                n_prod[i][k] = r_d[k]
                    * obbcp_pkg::word_s(obbcp_pkg::axis_of(i_cfg, 2'(i)), 2'(k));
            end
        end
    end

    // stage 3: dot product sum and clamp to the half extent
    always_comb begin
        logic signed [obbcp_pkg::PROJ_W-1:0] sum;
        logic signed [obbcp_pkg::PROJ_W-1:0] lim;
        n_inside = 1'b1;
        for (int i = 0; i < obbcp_pkg::AXES; i++) begin
            sum = r_prod[i][0] + r_prod[i][1] + r_prod[i][2];
            lim = $signed({{(obbcp_pkg::PROJ_W - obbcp_pkg::WORD_W
                             - obbcp_pkg::AXIS_FRAC){1'b0}},
                           obbcp_pkg::word_u(i_cfg.ext, 2'(i)),
                           {obbcp_pkg::AXIS_FRAC{1'b0}}});
            if (sum > lim) begin
                n_proj[i] = lim;
                n_inside  = 1'b0;
            end else if (sum < -lim) begin
                n_proj[i] = -lim;
                n_inside  = 1'b0;
            end else begin
                n_proj[i] = sum;
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_d <= n_d;
        end
        if (en2) begin
            r_prod <= n_prod;
        end
        if (en3) begin
            r_proj   <= n_proj;
            r_inside <= n_inside;
        end
    end

    // handoff bus
    always_comb begin
        o_bus.valid  = r_v3;
        o_bus.in_box = r_inside;
        for (int i = 0; i < obbcp_pkg::AXES; i++) begin
            o_bus.proj[i] = r_proj[i];
        end
    end

endmodule

`default_nettype wire

[rtl/obbcp_rebuild.sv]
// rebuild of the closest point from clamped projections, rounding and saturation
`timescale 1ns / 1ps
`default_nettype none

module obbcp_rebuild (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire obbcp_pkg::t_box_cfg                i_cfg,
    input  wire obbcp_pkg::t_proj_bus               i_bus,
    output      logic                               o_ready,
    output      logic                               o_valid,
    input  wire logic                               i_ready,
    output      logic [obbcp_pkg::OUT_TDATA_W-1:0]  o_data
);

    logic r_v4, r_v5, r_v6;
    logic en4, en5, en6;

    logic signed [obbcp_pkg::CPROD_W-1:0] r_cp   [obbcp_pkg::AXES][obbcp_pkg::AXES];
    logic signed [obbcp_pkg::CPROD_W-1:0] n_cp   [obbcp_pkg::AXES][obbcp_pkg::AXES];
    logic signed [obbcp_pkg::ACC_W-1:0]   r_acc  [obbcp_pkg::AXES];
    logic signed [obbcp_pkg::ACC_W-1:0]   n_acc  [obbcp_pkg::AXES];
    logic        [obbcp_pkg::WORD_W-1:0]  r_near [obbcp_pkg::AXES];
    logic        [obbcp_pkg::WORD_W-1:0]  n_near [obbcp_pkg::AXES];
    logic                                 r_in4, r_in5, r_in6;

    // stage enables, last stage is the output register
    assign en6     = !r_v6 || i_ready;
    assign en5     = !r_v5 || en6;
    assign en4     = !r_v4 || en5;
    assign o_ready = en4;

    // stage 4: clamped projection times each axis component
    always_comb begin
        for (int i = 0; i < obbcp_pkg::AXES; i++) begin
            for (int k = 0; k < obbcp_pkg::AXES; k++) begin
                n_cp[i][k] = $signed(i_bus.proj[i])
                    * obbcp_pkg::word_s(obbcp_pkg::axis_of(i_cfg, 2'(i)), 2'(k));
            end
        end
    end

    // stage 5: sum over axes with half lsb for rounding
    always_comb begin
        for (int k = 0; k < obbcp_pkg::AXES; k++) begin
            n_acc[k] = r_cp[0][k] + r_cp[1][k] + r_cp[2][k] + obbcp_pkg::ROUND_HALF;
        end
    end

    // stage 6: floor to q8.8, add center, saturate
    always_comb begin
        logic signed [obbcp_pkg::ACC_W-1:0] sh;
        logic signed [obbcp_pkg::OFF_W-1:0] off;
        logic signed [obbcp_pkg::SUM_W-1:0] sum;
        for (int k = 0; k < obbcp_pkg::AXES; k++) begin
            sh  = r_acc[k] >>> obbcp_pkg::FRAC_SHIFT;
            off = $signed(sh[obbcp_pkg::OFF_W-1:0]);
            sum = off + obbcp_pkg::word_s(i_cfg.center, 2'(k));
            if (sum > obbcp_pkg::SAT_HI) begin
                n_near[k] = obbcp_pkg::SAT_HI[obbcp_pkg::WORD_W-1:0];
            end else if (sum < obbcp_pkg::SAT_LO) begin
                n_near[k] = obbcp_pkg::SAT_LO[obbcp_pkg::WORD_W-1:0];
            end else begin
                n_near[k] = sum[obbcp_pkg::WORD_W-1:0];
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (en4) r_v4 <= i_bus.valid;
            if (en5) r_v5 <= r_v4;
            if (en6) r_v6 <= r_v5;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_cp  <= n_cp;
            r_in4 <= i_bus.in_box;
        end
        if (en5) begin
            r_acc <= n_acc;
            r_in5 <= r_in4;
        end
        if (en6) begin
            r_near <= n_near;
            r_in6  <= r_in5;
        end
    end

    assign o_valid = r_v6;
    assign o_data  = {{(obbcp_pkg::OUT_TDATA_W - obbcp_pkg::AXES * obbcp_pkg::WORD_W - 1){1'b0}},
                      r_in6, r_near[2], r_near[1], r_near[0]};

endmodule

`default_nettype wire

[rtl/obbcp_checker.sv]
// port-level checks for the closest point block and their binding
`timescale 1ns / 1ps
`default_nettype none

module obbcp_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              o_s_tready,
    input wire logic                              o_m_tvalid,
    input wire logic                              i_m_tready,
    input wire logic [obbcp_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output transfer changed while stalled");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    // an empty output slot never blocks the input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input blocked while output slot is free");

    // fill bits above the inside flag stay zero
    a_fill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[obbcp_pkg::OUT_TDATA_W-1:obbcp_pkg::OUT_TDATA_W-7] == '0)
        else $error("output fill bits not zero");

endmodule

bind obb_closest_point obbcp_checker u_obbcp_checker (.*);

`default_nettype wire
